@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/sha1md_pkg.sv @@
// Types, microcode and constants of the SHA-1 digest block.
package sha1md_pkg;

  localparam int StepW = 4;

  typedef struct packed {
    logic        cmd;
    logic [31:0] message_word;
    logic [2:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_item_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_IDLE  = 4'd1;
  localparam logic [3:0] OP_LOAD  = 4'd2;
  localparam logic [3:0] OP_ROUND = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd4;
  localparam logic [3:0] OP_PAD   = 4'd5;
  localparam logic [3:0] OP_ZERO  = 4'd6;
  localparam logic [3:0] OP_LENHI = 4'd7;
  localparam logic [3:0] OP_LENLO = 4'd8;
  localparam logic [3:0] OP_EMIT  = 4'd9;
  localparam logic [3:0] OP_INIT  = 4'd10;

  localparam logic [2:0] C_ALWAYS  = 3'd0;
  localparam logic [2:0] C_IDLE    = 3'd1;
  localparam logic [2:0] C_LAST    = 3'd2;
  localparam logic [2:0] C_FIN     = 3'd3;
  localparam logic [2:0] C_LENDONE = 3'd4;
  localparam logic [2:0] C_FULL    = 3'd5;
  localparam logic [2:0] C_WC14    = 3'd6;
  localparam logic [2:0] C_EMIT    = 3'd7;

  localparam logic [StepW-1:0] S_IDLE  = 4'd0;
  localparam logic [StepW-1:0] S_LOAD  = 4'd1;
  localparam logic [StepW-1:0] S_ROUND = 4'd2;
  localparam logic [StepW-1:0] S_ADD   = 4'd3;
  localparam logic [StepW-1:0] S_RET   = 4'd4;
  localparam logic [StepW-1:0] S_WHERE = 4'd5;
  localparam logic [StepW-1:0] S_PAD   = 4'd6;
  localparam logic [StepW-1:0] S_CHK   = 4'd7;
  localparam logic [StepW-1:0] S_ZERO  = 4'd8;
  localparam logic [StepW-1:0] S_LENHI = 4'd9;
  localparam logic [StepW-1:0] S_LENLO = 4'd10;
  localparam logic [StepW-1:0] S_EMIT  = 4'd11;
  localparam logic [StepW-1:0] S_INIT  = 4'd12;

  typedef struct packed {
    logic [3:0]       op;
    logic [2:0]       cond;
    logic [StepW-1:0] tgt_t;
    logic [StepW-1:0] tgt_f;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t uc;
    case (step)
      S_IDLE:  uc = '{OP_IDLE,  C_IDLE,    S_LOAD,  S_IDLE};
      S_LOAD:  uc = '{OP_LOAD,  C_ALWAYS,  S_ROUND, S_ROUND};
      S_ROUND: uc = '{OP_ROUND, C_LAST,    S_ADD,   S_ROUND};
      S_ADD:   uc = '{OP_ADD,   C_ALWAYS,  S_RET,   S_RET};
      S_RET:   uc = '{OP_NOP,   C_FIN,     S_WHERE, S_IDLE};
      S_WHERE: uc = '{OP_NOP,   C_LENDONE, S_EMIT,  S_CHK};
      S_PAD:   uc = '{OP_PAD,   C_FULL,    S_LOAD,  S_CHK};
      S_CHK:   uc = '{OP_NOP,   C_WC14,    S_LENHI, S_ZERO};
      S_ZERO:  uc = '{OP_ZERO,  C_FULL,    S_LOAD,  S_CHK};
      S_LENHI: uc = '{OP_LENHI, C_ALWAYS,  S_LENLO, S_LENLO};
      S_LENLO: uc = '{OP_LENLO, C_ALWAYS,  S_LOAD,  S_LOAD};
      S_EMIT:  uc = '{OP_EMIT,  C_EMIT,    S_INIT,  S_EMIT};
      S_INIT:  uc = '{OP_INIT,  C_ALWAYS,  S_IDLE,  S_IDLE};
      default: uc = '{OP_NOP,   C_ALWAYS,  S_IDLE,  S_IDLE};
    endcase
    return uc;
  endfunction

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6745_2301;
      3'd1:    v = 32'hefcd_ab89;
      3'd2:    v = 32'h98ba_dcfe;
      3'd3:    v = 32'h1032_5476;
      default: v = 32'hc3d2_e1f0;
    endcase
    return v;
  endfunction

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [3:0]  LEN_WORD   = 4'd14;
  localparam logic [3:0]  LAST_SLOT  = 4'd15;
  localparam logic [2:0]  LAST_OUT   = 3'd4;

endpackage

@@ rtl/sha1_message_digest_top.sv @@
// SHA-1 digest engine driven by a microcoded sequencer.
//
// Input channel (in_valid, in_stall, in_item): an absorb item carries one to
// four message bytes, first byte in bits 31..24; larger counts act as four
// and a count of zero is a no-op. A finish item pads the message, appends
// the bit length and produces the digest.
// Output channel (out_valid, out_stall, out_item): five digest words, word 0
// first, with last_word set on the fifth.
// When an absorb item completes a 64-byte block, the compression (load,
// the rounds on one round unit, add, one branch step) runs before the next
// transfer is taken.
// After a finish, the time to the first digest word depends on how many
// padding words and compressions the tail needs.
// A stalled digest word holds until its transfer; after the last word the
// block reinitializes itself for the next message.
// Reset is synchronous and loads the initial chaining value.
module sha1_message_digest_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1md_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha1md_pkg::out_item_t out_item
);

  logic [sha1md_pkg::StepW-1:0] step;
  logic [sha1md_pkg::StepW-1:0] step_next;
  sha1md_pkg::ucode_t           uc;

  logic [31:0] chain [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] wline [16];
  logic [6:0]  rnd;
  logic [3:0]  wc;
  logic [31:0] pend;
  logic [1:0]  pcnt;
  logic [60:0] blen;
  logic        fin;
  logic        lendone;
  logic [2:0]  oidx;

  logic        in_fire;
  logic        out_fire;
  logic [2:0]  nbytes;
  logic [2:0]  mcount;
  logic [31:0] mword;
  logic [31:0] mmask;
  logic [63:0] comb;
  logic [2:0]  total;
  logic        push;
  logic [31:0] push_word;
  logic        full;
  logic        cond_hit;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] w_new;

  function automatic logic [31:0] w_new_raw(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  assign uc       = sha1md_pkg::ucode_rom(step);
  assign in_stall = (uc.op != sha1md_pkg::OP_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_valid = (uc.op == sha1md_pkg::OP_EMIT);
  assign out_fire  = out_valid && !out_stall;

  assign nbytes = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;

  always_comb begin
    if (uc.op == sha1md_pkg::OP_PAD) begin
      mcount = 3'd1;
      mword  = sha1md_pkg::PAD_WORD;
    end else begin
      mcount = nbytes;
      mword  = in_item.message_word;
    end
    case (mcount)
      3'd0:    mmask = 32'h0000_0000;
      3'd1:    mmask = 32'hFF00_0000;
      3'd2:    mmask = 32'hFFFF_0000;
      3'd3:    mmask = 32'hFFFF_FF00;
      default: mmask = 32'hFFFF_FFFF;
    endcase
  end

  assign comb  = {pend, 32'h0} | ({mword & mmask, 32'h0} >> {pcnt, 3'b000});
  assign total = {1'b0, pcnt} + mcount;

  always_comb begin
    push      = 1'b0;
    push_word = comb[63:32];
    case (uc.op)
      sha1md_pkg::OP_IDLE: begin
        push = in_fire && (in_item.cmd == sha1md_pkg::CMD_ABSORB) && total[2];
      end
      sha1md_pkg::OP_PAD: begin
        push = 1'b1;
      end
      sha1md_pkg::OP_ZERO: begin
        push      = 1'b1;
        push_word = 32'h0;
      end
      sha1md_pkg::OP_LENHI: begin
        push      = 1'b1;
        push_word = blen[60:29];
      end
      sha1md_pkg::OP_LENLO: begin
        push      = 1'b1;
        push_word = {blen[28:0], 3'b000};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign full = push && (wc == sha1md_pkg::LAST_SLOT);

  always_comb begin
    case (uc.cond)
      sha1md_pkg::C_ALWAYS:  cond_hit = 1'b1;
      sha1md_pkg::C_LAST:    cond_hit = (rnd == sha1md_pkg::LAST_ROUND);
      sha1md_pkg::C_FIN:     cond_hit = fin;
      sha1md_pkg::C_LENDONE: cond_hit = lendone;
      sha1md_pkg::C_FULL:    cond_hit = full;
      sha1md_pkg::C_WC14:    cond_hit = (wc == sha1md_pkg::LEN_WORD);
      sha1md_pkg::C_EMIT:    cond_hit = out_fire && (oidx == sha1md_pkg::LAST_OUT);
      default:               cond_hit = full;
    endcase
    if (uc.cond == sha1md_pkg::C_IDLE && in_fire &&
        in_item.cmd == sha1md_pkg::CMD_FINISH) begin
      step_next = sha1md_pkg::S_PAD;
    end else if (cond_hit) begin
      step_next = uc.tgt_t;
    end else begin
      step_next = uc.tgt_f;
    end
  end

  always_comb begin
    if (rnd < 7'd20) begin
      f_val = d ^ (b & (c ^ d));
      k_val = sha1md_pkg::K0;
    end else if (rnd < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = sha1md_pkg::K1;
    end else if (rnd < 7'd60) begin
      f_val = (b & c) | (d & (b | c));
      k_val = sha1md_pkg::K2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = sha1md_pkg::K3;
    end
  end

  assign t_val = {a[26:0], a[31:27]} + f_val + e + k_val + wline[0];
  assign w_new = {w_new_raw(wline[13] ^ wline[8] ^ wline[2] ^ wline[0])};

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= sha1md_pkg::S_IDLE;
      wc      <= 4'd0;
      pend    <= 32'h0;
      pcnt    <= 2'd0;
      blen    <= 61'd0;
      fin     <= 1'b0;
      lendone <= 1'b0;
      oidx    <= 3'd0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1md_pkg::iv_word(3'(i));
      end
    end else begin
      step <= step_next;
      if (push) begin
        wc <= wc + 4'd1;
      end
      case (uc.op)
        sha1md_pkg::OP_IDLE: begin
          if (in_fire) begin
            if (in_item.cmd == sha1md_pkg::CMD_FINISH) begin
              fin <= 1'b1;
            end else begin
              blen <= blen + 61'(nbytes);
              if (total[2]) begin
                pend <= comb[31:0];
                pcnt <= total[1:0];
              end else begin
                pend <= comb[63:32];
                pcnt <= total[1:0];
              end
            end
          end
        end
        sha1md_pkg::OP_PAD: begin
          pend <= 32'h0;
          pcnt <= 2'd0;
        end
        sha1md_pkg::OP_LENLO: begin
          lendone <= 1'b1;
        end
        sha1md_pkg::OP_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
        end
        sha1md_pkg::OP_EMIT: begin
          if (out_fire) begin
            oidx <= oidx + 3'd1;
          end
        end
        sha1md_pkg::OP_INIT: begin
          wc      <= 4'd0;
          pend    <= 32'h0;
          pcnt    <= 2'd0;
          blen    <= 61'd0;
          fin     <= 1'b0;
          lendone <= 1'b0;
          oidx    <= 3'd0;
          for (int i = 0; i < 5; i++) begin
            chain[i] <= sha1md_pkg::iv_word(3'(i));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 15; i++) begin
        wline[i] <= wline[i + 1];
      end
      wline[15] <= push_word;
    end else if (uc.op == sha1md_pkg::OP_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        wline[i] <= wline[i + 1];
      end
      wline[15] <= w_new;
    end
    if (uc.op == sha1md_pkg::OP_LOAD) begin
      a   <= chain[0];
      b   <= chain[1];
      c   <= chain[2];
      d   <= chain[3];
      e   <= chain[4];
      rnd <= 7'd0;
    end else if (uc.op == sha1md_pkg::OP_ROUND) begin
      a   <= t_val;
      b   <= a;
      c   <= {b[1:0], b[31:2]};
      d   <= c;
      e   <= d;
      rnd <= rnd + 7'd1;
    end
  end

  always_comb begin
    case (oidx)
      3'd0:    out_item.digest_word = chain[0];
      3'd1:    out_item.digest_word = chain[1];
      3'd2:    out_item.digest_word = chain[2];
      3'd3:    out_item.digest_word = chain[3];
      default: out_item.digest_word = chain[4];
    endcase
    out_item.last_word = (oidx == sha1md_pkg::LAST_OUT);
  end

endmodule

@@ rtl/sha1md_check.sv @@
// Port-level checker for the SHA-1 digest block and its bind statement.
`include "assert_macros.svh"

module sha1md_check (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input sha1md_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input logic                  out_stall,
  input sha1md_pkg::out_item_t out_item
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
  `ASSERT_NOW(a_busy_emit, clk, rst, out_valid, in_stall)
  `ASSERT_NEXT(a_last_ends, clk, rst, out_valid && !out_stall && out_item.last_word, !out_valid)
  `ASSERT_NEXT(a_finish_busy, clk, rst, in_valid && !in_stall && in_item.cmd, in_stall && !out_valid)

endmodule

bind sha1_message_digest_top sha1md_check u_sha1md_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ bench/tb_sha1_message_digest_top.sv @@
// Self-checking testbench for the SHA-1 digest block with a digest-predicting scoreboard.
`timescale 1ns / 1ps

module tb_sha1_message_digest_top;

  localparam logic [31:0] ROUND_K0 = 32'h5A82_7999;
  localparam logic [31:0] ROUND_K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] ROUND_K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] ROUND_K3 = 32'hCA62_C1D6;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEM_TARGET = 160;
  localparam int MESSAGE_TARGET = 12;

  class sha1_digest_scoreboard;
    logic [31:0] chain [5];
    logic [7:0]  block_bytes [64];
    int unsigned fill;
    logic [63:0] bit_len;
    sha1md_pkg::out_item_t digest_words_due [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h6745_2301;
      chain[1] = 32'hefcd_ab89;
      chain[2] = 32'h98ba_dcfe;
      chain[3] = 32'h1032_5476;
      chain[4] = 32'hc3d2_e1f0;
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
      fill = 0;
      bit_len = 64'd0;
    endfunction

    function void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) begin
        w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      for (int i = 16; i < 80; i++) begin
        x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {x[30:0], x[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = d ^ (b & (c ^ d));
          k = ROUND_K0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = ROUND_K1;
        end else if (i < 60) begin
          f = (b & c) | (d & (b | c));
          k = ROUND_K2;
        end else begin
          f = b ^ c ^ d;
          k = ROUND_K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
      fill = 0;
    endfunction

    function void note_transfer(input sha1md_pkg::in_item_t it);
      int unsigned n;
      sha1md_pkg::out_item_t word;
      if (it.cmd == sha1md_pkg::CMD_ABSORB) begin
        n = (it.byte_count > 3'd4) ? 4 : it.byte_count;
        for (int i = 0; i < n; i++) begin
          block_bytes[fill] = it.message_word[31-8*i -: 8];
          fill++;
          if (fill == 64) compress_block();
        end
        bit_len += 64'(n * 8);
      end else begin
        block_bytes[fill] = 8'h80;
        if (fill >= 56) compress_block();
        for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 5; i++) begin
          word.digest_word = chain[i];
          word.last_word = (i == 4);
          digest_words_due.push_back(word);
        end
        restart();
      end
    endfunction

    function void check_digest_word(input sha1md_pkg::out_item_t got);
      sha1md_pkg::out_item_t want;
      if (digest_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected digest word %h last %0d", $realtime, got.digest_word,
                   got.last_word);
      end else begin
        want = digest_words_due.pop_front();
        if (got.digest_word !== want.digest_word || got.last_word !== want.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: digest word mismatch: expected %h last %0d, got %h last %0d",
                     $realtime, want.digest_word, want.last_word, got.digest_word,
                     got.last_word);
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sha1md_pkg::in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sha1md_pkg::out_item_t out_item;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_done = 0;
  int unsigned messages_done = 0;
  int unsigned quiet_cycles = 0;
  sha1_digest_scoreboard sb;

  sha1_message_digest_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= !rst && (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_transfer(in_item);
      if (out_valid && !out_stall) sb.check_digest_word(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input sha1md_pkg::in_item_t it);
    if (items_done < 55) begin
      send_idle_pct = 33;
      recv_stall_pct = 58;
    end else if (items_done < 110) begin
      send_idle_pct = 58;
      recv_stall_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    if (it.cmd == sha1md_pkg::CMD_FINISH || it.byte_count != 3'd0) items_done++;
    if (it.cmd == sha1md_pkg::CMD_FINISH) messages_done++;
  endtask

  task automatic send_absorb(input logic [31:0] word, input logic [2:0] count);
    sha1md_pkg::in_item_t it;
    it.cmd = sha1md_pkg::CMD_ABSORB;
    it.message_word = word;
    it.byte_count = count;
    send_item(it);
  endtask

  task automatic send_finish(input logic [31:0] word, input logic [2:0] count);
    sha1md_pkg::in_item_t it;
    it.cmd = sha1md_pkg::CMD_FINISH;
    it.message_word = word;
    it.byte_count = count;
    send_item(it);
  endtask

  task automatic send_message(input int unsigned n_bytes);
    int unsigned left;
    int unsigned max_take;
    logic [2:0] count;
    left = n_bytes;
    while (left > 0) begin
      max_take = (left < 4) ? left : 4;
      case ($urandom_range(9))
        0:       count = 3'd0;
        1:       count = (left >= 4) ? 3'($urandom_range(7, 5)) : 3'(max_take);
        2, 3:    count = 3'($urandom_range(1, max_take));
        default: count = 3'(max_take);
      endcase
      send_absorb($urandom(), count);
      left -= (count > 3'd4) ? 4 : count;
    end
    send_finish($urandom(), 3'($urandom_range(7)));
  endtask

  initial begin
    int unsigned edge_lens [8];
    int unsigned len;
    edge_lens = '{55, 56, 63, 64, 119, 120, 127, 128};
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_finish(32'hFFFF_FFFF, 3'd7);
    send_absorb(32'hFFFF_FFFF, 3'd0);
    send_absorb(32'hFFFF_FFFF, 3'd4);
    send_absorb(32'h0000_0000, 3'd1);
    send_absorb(32'h0000_0000, 3'd2);
    send_absorb(32'h0000_0000, 3'd3);
    send_absorb($urandom(), 3'd5);
    send_absorb($urandom(), 3'd6);
    send_absorb($urandom(), 3'd7);
    send_finish(32'h0000_0000, 3'd0);
    send_absorb(32'h6162_63FF, 3'd3);
    send_finish($urandom(), 3'd4);

    while (items_done < ITEM_TARGET || messages_done < MESSAGE_TARGET) begin
      case ($urandom_range(7))
        0, 1, 2: len = $urandom_range(20);
        3, 4:    len = $urandom_range(70, 50);
        5:       len = $urandom_range(132, 110);
        default: len = edge_lens[$urandom_range(7)];
      endcase
      send_message(len);
    end
    in_valid <= 1'b0;

    while (sb.digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.digest_words_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
